// ===== hw/rtl/pcwe_pkg.sv =====
// ----------------------------------------------------------------------------
// pcwe_pkg
// types, command codes, register addresses and helpers of the square channel
// ----------------------------------------------------------------------------
package pcwe_pkg;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_LENGTH   = 3'd1,
        CMD_ENVELOPE = 3'd2,
        CMD_READ     = 3'd3,
        CMD_WRITE    = 3'd4,
        CMD_POWER    = 3'd5
    } cmd_t;

    localparam logic [15:0] ADDR_DUTY_LEN = 16'hff16;
    localparam logic [15:0] ADDR_ENVELOPE = 16'hff17;
    localparam logic [15:0] ADDR_FREQ_LO  = 16'hff18;
    localparam logic [15:0] ADDR_FREQ_HI  = 16'hff19;

    localparam logic [7:0]  OPEN_BUS      = 8'hff;
    localparam logic [6:0]  LENGTH_FULL   = 7'd64;
    localparam logic [12:0] PERIOD_BASE   = 13'd4096;

    // one input item
    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic        sequencer_odd;
        logic        power_sets_length;
    } item_t;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic [3:0] sample;
        logic       channel_on;
        logic       dac_on;
    } result_t;

    // channel state
    typedef struct packed {
        logic        enabled;
        logic [1:0]  duty_select;
        logic [6:0]  length_left;
        logic [3:0]  initial_volume;
        logic        ramp_up;
        logic [2:0]  ramp_rate;
        logic [10:0] tone_frequency;
        logic        length_enable;
        logic [3:0]  level_out;
        logic        duty_high;
        logic [2:0]  duty_step;
        logic [12:0] period_count;
        logic [2:0]  ramp_count;
        logic [3:0]  volume_now;
    } chan_state_t;

    function automatic logic dac_enabled(input logic [3:0] vol, input logic up);
        return (vol != 4'd0) || up;
    endfunction

    // 2 * (2048 - frequency)
    function automatic logic [12:0] period_reload(input logic [10:0] freq);
        return PERIOD_BASE - {1'b0, freq, 1'b0};
    endfunction

    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
        logic bit_out;
        case (sel)
            2'd0: bit_out = (step == 3'd6);
            2'd1: bit_out = (step >= 3'd6);
            2'd2: bit_out = (step >= 3'd4);
            default: bit_out = (step <= 3'd5);
        endcase
        return bit_out;
    endfunction

    // power-up clears everything; length is kept unless reloaded
    function automatic chan_state_t power_state(input logic set_len,
                                                input logic [6:0] len_now);
        chan_state_t st;
        st = '0;
        st.length_left = set_len ? LENGTH_FULL : len_now;
        return st;
    endfunction

endpackage

// ===== hw/rtl/pcwe_chan.sv =====
// ----------------------------------------------------------------------------
// pcwe_chan
// channel state register and the single-pass update for one command
// ----------------------------------------------------------------------------
module pcwe_chan
    import pcwe_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    output result_t result
);

    chan_state_t st_reg;
    chan_state_t st_next;
    logic [7:0]  rd;
    logic [6:0]  len_q;
    logic        en_q;

    always_comb begin
        st_next = st_reg;
        rd      = OPEN_BUS;
        len_q   = st_reg.length_left;
        en_q    = st_reg.enabled;
        case (item.command)
            CMD_TICK: begin
                if (st_reg.period_count != 13'd0) begin
                    st_next.period_count = st_reg.period_count - 13'd1;
                    if (st_next.period_count == 13'd0) begin
                        st_next.period_count = period_reload(st_reg.tone_frequency);
                        st_next.duty_step    = st_reg.duty_step + 3'd1;
                        st_next.duty_high    = duty_bit(st_reg.duty_select,
                                                        st_next.duty_step);
                    end
                end
                st_next.level_out = (st_next.duty_high && st_reg.enabled) ?
                                    st_reg.volume_now : 4'd0;
            end
            CMD_LENGTH: begin
                if (st_reg.length_enable && st_reg.length_left != 7'd0) begin
                    st_next.length_left = st_reg.length_left - 7'd1;
                    if (st_next.length_left == 7'd0) begin
                        st_next.enabled = 1'b0;
                    end
                end
            end
            CMD_ENVELOPE: begin
                if (st_reg.enabled && st_reg.ramp_rate != 3'd0) begin
                    st_next.ramp_count = st_reg.ramp_count - 3'd1;
                    if (st_next.ramp_count == 3'd0) begin
                        st_next.ramp_count = st_reg.ramp_rate;
                        if (!st_reg.ramp_up && st_reg.volume_now != 4'd0) begin
                            st_next.volume_now = st_reg.volume_now - 4'd1;
                        end
                        if (st_reg.ramp_up && st_reg.volume_now != 4'd15) begin
                            st_next.volume_now = st_reg.volume_now + 4'd1;
                        end
                    end
                end
            end
            CMD_READ: begin
                case (item.address)
                    ADDR_DUTY_LEN: rd = {st_reg.duty_select, 6'h3f};
                    ADDR_ENVELOPE: rd = {st_reg.initial_volume, st_reg.ramp_up,
                                         st_reg.ramp_rate};
                    ADDR_FREQ_HI:  rd = {1'b1, st_reg.length_enable, 6'h3f};
                    default:       rd = OPEN_BUS;
                endcase
            end
            CMD_WRITE: begin
                case (item.address)
                    ADDR_DUTY_LEN: begin
                        st_next.duty_select = item.write_data[7:6];
                        st_next.length_left = LENGTH_FULL - {1'b0, item.write_data[5:0]};
                    end
                    ADDR_ENVELOPE: begin
                        st_next.initial_volume = item.write_data[7:4];
                        st_next.ramp_up        = item.write_data[3];
                        st_next.ramp_rate      = item.write_data[2:0];
                        if (!dac_enabled(item.write_data[7:4], item.write_data[3])) begin
                            st_next.enabled = 1'b0;
                        end
                    end
                    ADDR_FREQ_LO: begin
                        st_next.tone_frequency[7:0] = item.write_data;
                    end
                    ADDR_FREQ_HI: begin
                        // enabling length on an odd sequencer step clocks it once
                        if (item.sequencer_odd && !st_reg.length_enable &&
                            item.write_data[6] && len_q != 7'd0) begin
                            len_q = len_q - 7'd1;
                            if (len_q == 7'd0) begin
                                en_q = 1'b0;
                            end
                        end
                        st_next.length_left          = len_q;
                        st_next.enabled              = en_q;
                        st_next.length_enable        = item.write_data[6];
                        st_next.tone_frequency[10:8] = item.write_data[2:0];
                        if (item.write_data[7]) begin
                            st_next.enabled      = dac_enabled(st_reg.initial_volume,
                                                               st_reg.ramp_up);
                            st_next.period_count = period_reload(st_next.tone_frequency);
                            st_next.ramp_count   = st_reg.ramp_rate;
                            st_next.volume_now   = st_reg.initial_volume;
                            if (len_q == 7'd0) begin
                                st_next.length_left =
                                    (item.sequencer_odd && item.write_data[6]) ?
                                    LENGTH_FULL - 7'd1 : LENGTH_FULL;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            CMD_POWER: begin
                st_next = power_state(item.power_sets_length, st_reg.length_left);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= power_state(1'b1, 7'd0);
        end else if (step_en) begin
            st_reg <= st_next;
        end
    end

    assign result.read_data  = rd;
    assign result.sample     = st_next.level_out;
    assign result.channel_on = st_next.enabled;
    assign result.dac_on     = dac_enabled(st_next.initial_volume, st_next.ramp_up);

`ifndef NO_ASSERTIONS
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.length_left <= LENGTH_FULL)
        else $error("length counter above 64");

    a_on_needs_dac: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.enabled |-> dac_enabled(st_reg.initial_volume, st_reg.ramp_up))
        else $error("channel on with dac off");

    a_period_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.period_count <= PERIOD_BASE)
        else $error("period counter out of range");
`endif

endmodule

// ===== hw/rtl/pulse_channel_with_envelope_core.sv =====
// ----------------------------------------------------------------------------
// pulse_channel_with_envelope_core
// square-wave sound channel with length counter and volume envelope
// ----------------------------------------------------------------------------
// path: an input transaction is captured in the input register, then its result
//   is registered in the result register, which drives m_tdata
// throughput: one transaction per cycle unless m_tready stalls; the update is
//   a single pass between the input register and the result register
// reset: aresetn low (synchronous) empties both stages and loads the channel
//   state with its power-up values, length counter at 64
// ----------------------------------------------------------------------------
module pulse_channel_with_envelope_core
    import pcwe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // address[15:0], write_data[23:16],
                                   // sequencer_odd[24], power_sets_length[25]
    input  logic [2:0]  s_tuser,   // command[2:0]

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // read_data[7:0], sample[11:8],
                                   // channel_on[12], dac_on[13]
);

    // input register stage
    logic    in_valid_reg;
    item_t   in_item_reg;

    // result register stage
    logic    out_valid_reg;
    result_t out_result_reg;

    result_t step_result;
    logic    advance;

    // the input stage moves on when the result register is free or drains now
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // payload capture, unpacking the stream fields
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.command           <= s_tuser;
            in_item_reg.address           <= s_tdata[15:0];
            in_item_reg.write_data        <= s_tdata[23:16];
            in_item_reg.sequencer_odd     <= s_tdata[24];
            in_item_reg.power_sets_length <= s_tdata[25];
        end
    end

    // channel state and its one-pass update, committed when the item advances
    pcwe_chan u_chan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_result_reg.dac_on, out_result_reg.channel_on,
                       out_result_reg.sample, out_result_reg.read_data};

`ifndef NO_ASSERTIONS
    a_stall_holds_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !advance) |=> !m_tvalid)
        else $error("result register kept a taken transaction");

    a_read_only_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.command != CMD_READ) |=>
            (out_result_reg.read_data == OPEN_BUS))
        else $error("read data from a non-read command");
`endif

endmodule

// ===== sim/channel_monitor.sv =====
// ----------------------------------------------------------------------------
// channel_monitor
// watches both streams of the square channel, predicts every result from the
// accepted commands and compares it field by field with what comes out
// ----------------------------------------------------------------------------
module channel_monitor
    import pcwe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        on;
        logic [1:0]  duty_sel;
        logic [6:0]  len;
        logic [3:0]  vol_init;
        logic        dir_up;
        logic [2:0]  env_period;
        logic [10:0] freq;
        logic        len_en;
        logic [3:0]  level;
        logic        wave_hi;
        logic [2:0]  phase;
        logic [12:0] timer;
        logic [2:0]  env_timer;
        logic [3:0]  vol;
    } channel_t;

    channel_t ch;
    result_t  channel_outputs[$];
    int       mismatches = 0;

    // twice the distance of the frequency from 2048
    function automatic logic [12:0] period_of(input logic [10:0] f);
        logic [12:0] span;
        span = 13'd2048 - {2'b00, f};
        return span << 1;
    endfunction

    function automatic logic wave_level(input logic [1:0] sel, input logic [2:0] ph);
        logic hi;
        case (sel)
            2'd0:    hi = (ph == 3'd6);
            2'd1:    hi = (ph[2:1] == 2'b11);
            2'd2:    hi = ph[2];
            default: hi = (ph < 3'd6);
        endcase
        return hi;
    endfunction

    function automatic logic dac_of(input channel_t c);
        return (c.vol_init != 4'd0) || c.dir_up;
    endfunction

    task automatic power_up(input logic reload_len);
        logic [6:0] keep;
        keep   = ch.len;
        ch     = '0;
        ch.len = reload_len ? 7'd64 : keep;
    endtask

    task automatic clock_length();
        if (ch.len != 7'd0) begin
            ch.len = ch.len - 7'd1;
            if (ch.len == 7'd0) ch.on = 1'b0;
        end
    endtask

    task automatic register_write(input logic [15:0] addr, input logic [7:0] d,
                                  input logic odd);
        case (addr)
            ADDR_DUTY_LEN: begin
                ch.duty_sel = d[7:6];
                ch.len      = 7'd64 - {1'b0, d[5:0]};
            end
            ADDR_ENVELOPE: begin
                ch.vol_init   = d[7:4];
                ch.dir_up     = d[3];
                ch.env_period = d[2:0];
                if (!dac_of(ch)) ch.on = 1'b0;
            end
            ADDR_FREQ_LO: begin
                ch.freq[7:0] = d;
            end
            ADDR_FREQ_HI: begin
                // enabling the length counter on an odd step clocks it once
                if (odd && !ch.len_en && d[6]) clock_length();
                ch.len_en     = d[6];
                ch.freq[10:8] = d[2:0];
                if (d[7]) begin
                    ch.on        = dac_of(ch);
                    ch.timer     = period_of(ch.freq);
                    ch.env_timer = ch.env_period;
                    ch.vol       = ch.vol_init;
                    if (ch.len == 7'd0) ch.len = (odd && ch.len_en) ? 7'd63 : 7'd64;
                end
            end
            default: ;
        endcase
    endtask

    task automatic advance_channel(input logic [2:0] cmd, input logic [15:0] addr,
                                   input logic [7:0] d, input logic odd,
                                   input logic setlen, output result_t r);
        r.read_data = OPEN_BUS;
        case (cmd)
            CMD_TICK: begin
                // a stopped timer stays stopped
                if (ch.timer != 13'd0) begin
                    ch.timer = ch.timer - 13'd1;
                    if (ch.timer == 13'd0) begin
                        ch.timer   = period_of(ch.freq);
                        ch.phase   = ch.phase + 3'd1;
                        ch.wave_hi = wave_level(ch.duty_sel, ch.phase);
                    end
                end
                ch.level = (ch.wave_hi && ch.on) ? ch.vol : 4'd0;
            end
            CMD_LENGTH: begin
                if (ch.len_en) clock_length();
            end
            CMD_ENVELOPE: begin
                if (ch.on && ch.env_period != 3'd0) begin
                    ch.env_timer = ch.env_timer - 3'd1;
                    if (ch.env_timer == 3'd0) begin
                        ch.env_timer = ch.env_period;
                        if (!ch.dir_up && ch.vol != 4'd0) ch.vol = ch.vol - 4'd1;
                        if (ch.dir_up && ch.vol != 4'd15) ch.vol = ch.vol + 4'd1;
                    end
                end
            end
            CMD_READ: begin
                case (addr)
                    ADDR_DUTY_LEN: r.read_data = {ch.duty_sel, 6'h3f};
                    ADDR_ENVELOPE: r.read_data = {ch.vol_init, ch.dir_up, ch.env_period};
                    ADDR_FREQ_HI:  r.read_data = {1'b1, ch.len_en, 6'h3f};
                    default:       r.read_data = OPEN_BUS;
                endcase
            end
            CMD_WRITE: register_write(addr, d, odd);
            CMD_POWER: power_up(setlen);
            default: ;
        endcase
        r.sample     = ch.level;
        r.channel_on = ch.on;
        r.dac_on     = dac_of(ch);
    endtask

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        result_t fresh;
        if (!aresetn) begin
            power_up(1'b1);
            channel_outputs.delete();
        end else begin
            // a result leaving now belongs to an earlier command
            if (m_tvalid && m_tready) begin
                got.read_data  = m_tdata[7:0];
                got.sample     = m_tdata[11:8];
                got.channel_on = m_tdata[12];
                got.dac_on     = m_tdata[13];
                if (channel_outputs.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, m_tdata);
                end else begin
                    want = channel_outputs.pop_front();
                    if (got.read_data !== want.read_data || got.sample !== want.sample ||
                        got.channel_on !== want.channel_on ||
                        got.dac_on !== want.dac_on) begin
                        mismatches++;
                        $display({"%0t: mismatch, expected rd=%h smp=%h on=%b dac=%b,",
                                  " got rd=%h smp=%h on=%b dac=%b"},
                                 $time, want.read_data, want.sample, want.channel_on,
                                 want.dac_on, got.read_data, got.sample,
                                 got.channel_on, got.dac_on);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                advance_channel(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[24],
                                s_tdata[25], fresh);
                channel_outputs.push_back(fresh);
            end
        end
        fail_count  <= mismatches;
        outstanding <= channel_outputs.size();
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives command transactions into the square channel under random idling and
// back-pressure; the monitor beside the block checks every result
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pcwe_pkg::*;

    // command codes the block treats as no-ops
    localparam logic [2:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
    // unused register below the channel's own
    localparam logic [15:0] ADDR_SWEEP   = 16'hff15;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          PHASE_ITEMS  = 385;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int fail_count;
    int outstanding;

    always #10 aclk = ~aclk;

    pulse_channel_with_envelope_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    channel_monitor u_monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // result side: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_served + 1;
            hold_left   = HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic item_t make_item(input logic [2:0] cmd, input logic [15:0] addr,
                                        input logic [7:0] d, input logic odd,
                                        input logic setlen);
        item_t it;
        it.command           = cmd;
        it.address           = addr;
        it.write_data        = d;
        it.sequencer_odd     = odd;
        it.power_sets_length = setlen;
        return it;
    endfunction

    // mostly channel registers and fast tones so the duty phase moves
    function automatic item_t random_item();
        item_t it;
        int    pick;
        pick                 = $urandom_range(99);
        it.address           = ($urandom_range(99) < 85) ?
                               ADDR_SWEEP + 16'($urandom_range(4)) : 16'($urandom);
        it.write_data        = 8'($urandom);
        it.sequencer_odd     = 1'($urandom);
        it.power_sets_length = 1'($urandom);
        if (pick < 35)      it.command = CMD_TICK;
        else if (pick < 45) it.command = CMD_LENGTH;
        else if (pick < 55) it.command = CMD_ENVELOPE;
        else if (pick < 67) it.command = CMD_READ;
        else if (pick < 96) it.command = CMD_WRITE;
        else if (pick < 98) it.command = CMD_POWER;
        else                it.command = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
        if (it.address == ADDR_FREQ_LO && $urandom_range(9) < 7)
            it.write_data[7:4] = 4'hf;
        if (it.address == ADDR_FREQ_HI && $urandom_range(9) < 7)
            it.write_data[2:0] = 3'b111;
        return it;
    endfunction

    // one transaction on the command stream, with random idle cycles ahead
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.command;
        s_tdata  <= {6'd0, it.power_sets_length, it.sequencer_odd, it.write_data,
                     it.address};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // full register setup ending in a trigger
    task automatic program_channel();
        logic [7:0] env;
        env = 8'($urandom);
        if (env[7:3] == 5'd0 && $urandom_range(3) != 0) env[7:4] = 4'($urandom_range(1, 15));
        send_item(make_item(CMD_WRITE, ADDR_DUTY_LEN, 8'($urandom), 1'($urandom), 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_ENVELOPE, env, 1'($urandom), 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FREQ_LO, {4'hf, 4'($urandom)}, 1'($urandom),
                            1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FREQ_HI,
                            {1'b1, 1'($urandom), 3'($urandom), 3'b111}, 1'($urandom),
                            1'b0));
    endtask

    task automatic run_random(input int count, input int hold_at);
        int sent;
        sent = 0;
        while (sent < count) begin
            // ask for one long hold-off while commands keep coming
            if (sent >= hold_at && hold_at >= 0 && hold_requests == hold_served
                && hold_left == 0 && sent < hold_at + 4)
                hold_requests = hold_requests + 1;
            if ($urandom_range(99) < 15) begin
                program_channel();
                sent += 4;
            end else begin
                send_item(random_item());
                sent++;
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: power both ways, every register, the length quirks, dac off
        send_item(make_item(CMD_POWER, 16'h0000, 8'h00, 1'b0, 1'b1));
        send_item(make_item(CMD_POWER, 16'hffff, 8'hff, 1'b1, 1'b0));
        send_item(make_item(CMD_READ, ADDR_SWEEP, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_DUTY_LEN, 8'hff, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_ENVELOPE, 8'hf3, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FREQ_LO, 8'hff, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FREQ_HI, 8'h87, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, ADDR_DUTY_LEN, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, ADDR_ENVELOPE, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, ADDR_FREQ_LO, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_READ, ADDR_FREQ_HI, 8'h00, 1'b0, 1'b0));
        repeat (3) send_item(make_item(CMD_TICK, 16'h0000, 8'h00, 1'b0, 1'b0));
        repeat (3) send_item(make_item(CMD_ENVELOPE, 16'h0000, 8'h00, 1'b0, 1'b0));
        // enabling length on an odd step runs it out, then a trigger reloads 63
        send_item(make_item(CMD_WRITE, ADDR_FREQ_HI, 8'h47, 1'b1, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_FREQ_HI, 8'hc7, 1'b1, 1'b0));
        send_item(make_item(CMD_LENGTH, 16'h0000, 8'h00, 1'b0, 1'b0));
        // zero volume with downward ramp switches the channel off
        send_item(make_item(CMD_WRITE, ADDR_ENVELOPE, 8'h00, 1'b1, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_ENVELOPE, 8'h08, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, ADDR_DUTY_LEN, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_WRITE, 16'hffff, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_SPARE_LO, 16'h0000, 8'h00, 1'b0, 1'b0));
        send_item(make_item(CMD_SPARE_HI, 16'hffff, 8'hff, 1'b1, 1'b1));

        // random phases: no idling with one long hold-off, sender idle,
        // receiver stalling, both
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random(PHASE_ITEMS, PHASE_ITEMS / 2);
        send_idle_pct = 69;
        stall_pct     = 0;
        run_random(PHASE_ITEMS, -1);
        send_idle_pct = 0;
        stall_pct     = 69;
        run_random(PHASE_ITEMS, -1);
        send_idle_pct = 14;
        stall_pct     = 14;
        run_random(PHASE_ITEMS, -1);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/pcwe_pkg.sv
hw/rtl/pcwe_chan.sv
hw/rtl/pulse_channel_with_envelope_core.sv
sim/channel_monitor.sv
sim/testbench.sv
